// ===== rtl/s4rp_pkg.sv =====
// shared types and codes for the socks4a request parser
// no dependencies

package s4rp_pkg;

    localparam logic [7:0] SOCKS_VERSION    = 8'd4;
    localparam logic [7:0] CMD_CONNECT      = 8'd1;
    localparam logic [7:0] CMD_BIND         = 8'd2;
    localparam logic [7:0] NAME_LIMIT_RESET = 8'd255;
    localparam logic [7:0] CHAR_NUL         = 8'h00;
    localparam logic [7:0] CHAR_DOT         = 8'h2e;
    localparam logic [7:0] CHAR_DASH        = 8'h2d;

    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [3:0] {
        PH_VERSION  = 4'd0,
        PH_COMMAND  = 4'd1,
        PH_PORT_HI  = 4'd2,
        PH_PORT_LO  = 4'd3,
        PH_IP_1     = 4'd4,
        PH_IP_2     = 4'd5,
        PH_IP_3     = 4'd6,
        PH_IP_4     = 4'd7,
        PH_USERID   = 4'd8,
        PH_HOSTNAME = 4'd9,
        PH_DONE     = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        ST_MORE   = 2'd0,
        ST_DONE   = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

endpackage

// ===== rtl/socks4a_request_parser.sv =====
// socks4a request parser top level, one request byte per transaction
// depends on s4rp_pkg

// Usage:
//   input channel  : i_in_valid / o_in_ready carry i_op and i_data_byte; op restart
//                    clears the parse state and returns to the version phase
//   output channel : o_out_valid / i_out_ready carry one result per input byte:
//                    status, command, port, address and the appended name char
//   config channel : i_cfg_valid / o_cfg_ready write max_name_length from
//                    i_cfg_data; always ready, write only while idle
//   latency        : result is valid the cycle after the input is accepted
//   throughput     : one byte per cycle while not stalled, set by the single phase
//                    register update and the output register that follows it
//   stall          : the output register holds its result while i_out_ready is
//                    low; o_in_ready is high when the output register is empty
//                    or is being drained in the same cycle
//   reset          : synchronous active low; phase returns to version, all parse
//                    registers clear, limit returns to 255, output is empty

module socks4a_request_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_command_code,
    output logic [15:0] o_dest_port,
    output logic [31:0] o_dest_ip,
    output logic        o_name_char_valid,
    output logic [7:0]  o_name_char,
    output logic        o_name_is_hostname,
    output logic [7:0]  o_name_length
);

    s4rp_pkg::t_phase  r_phase, n_phase;
    s4rp_pkg::t_status n_status;
    logic [7:0]  r_max_len;
    logic [7:0]  r_command, n_command;
    logic [15:0] r_port, n_port;
    logic [31:0] r_addr, n_addr;
    logic [7:0]  r_uid_cnt, n_uid_cnt;
    logic [7:0]  r_host_cnt, n_host_cnt;
    logic        n_cvalid, n_is_host;
    logic [7:0]  n_cval, n_nlen;

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [7:0]  r_out_command;
    logic [15:0] r_out_port;
    logic [31:0] r_out_addr;
    logic        r_cvalid;
    logic [7:0]  r_cval;
    logic        r_is_host;
    logic [7:0]  r_nlen;

    logic in_fire;
    logic byte_ok;
    logic host_form;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    assign byte_ok = ((i_data_byte >= 8'h41) && (i_data_byte <= 8'h5a))
                  || ((i_data_byte >= 8'h61) && (i_data_byte <= 8'h7a))
                  || ((i_data_byte >= 8'h30) && (i_data_byte <= 8'h39))
                  || (i_data_byte == s4rp_pkg::CHAR_NUL)
                  || (i_data_byte == s4rp_pkg::CHAR_DOT)
                  || (i_data_byte == s4rp_pkg::CHAR_DASH);

    assign host_form = (r_addr[31:8] == 24'd0) && (r_addr[7:0] != 8'd0);

    // next phase and parse registers
    always_comb begin
        n_phase    = r_phase;
        n_command  = r_command;
        n_port     = r_port;
        n_addr     = r_addr;
        n_uid_cnt  = r_uid_cnt;
        n_host_cnt = r_host_cnt;
        if (i_op == s4rp_pkg::OP_RESTART) begin
            n_phase    = s4rp_pkg::PH_VERSION;
            n_command  = 8'd0;
            n_port     = 16'd0;
            n_addr     = 32'd0;
            n_uid_cnt  = 8'd0;
            n_host_cnt = 8'd0;
        end else begin
            unique case (r_phase)
                s4rp_pkg::PH_VERSION: begin
                    if (i_data_byte == s4rp_pkg::SOCKS_VERSION) n_phase = s4rp_pkg::PH_COMMAND;
                end
                s4rp_pkg::PH_COMMAND: begin
                    if ((i_data_byte == s4rp_pkg::CMD_CONNECT)
                            || (i_data_byte == s4rp_pkg::CMD_BIND)) begin
                        n_command = i_data_byte;
                        n_phase   = s4rp_pkg::PH_PORT_HI;
                    end
                end
                s4rp_pkg::PH_PORT_HI: begin
                    n_port  = {i_data_byte, 8'd0};
                    n_phase = s4rp_pkg::PH_PORT_LO;
                end
                s4rp_pkg::PH_PORT_LO: begin
                    n_port  = {r_port[15:8], i_data_byte};
                    n_phase = s4rp_pkg::PH_IP_1;
                end
                s4rp_pkg::PH_IP_1: begin
                    n_addr  = {i_data_byte, 24'd0};
                    n_phase = s4rp_pkg::PH_IP_2;
                end
                s4rp_pkg::PH_IP_2: begin
                    n_addr  = {r_addr[31:24], i_data_byte, r_addr[15:0]};
                    n_phase = s4rp_pkg::PH_IP_3;
                end
                s4rp_pkg::PH_IP_3: begin
                    n_addr  = {r_addr[31:16], i_data_byte, r_addr[7:0]};
                    n_phase = s4rp_pkg::PH_IP_4;
                end
                s4rp_pkg::PH_IP_4: begin
                    n_addr  = {r_addr[31:8], i_data_byte};
                    n_phase = s4rp_pkg::PH_USERID;
                end
                s4rp_pkg::PH_USERID: begin
                    if (byte_ok && (r_uid_cnt < r_max_len)) begin
                        if (i_data_byte == s4rp_pkg::CHAR_NUL) begin
                            n_phase = host_form ? s4rp_pkg::PH_HOSTNAME
                                                : s4rp_pkg::PH_DONE;
                        end else begin
                            n_uid_cnt = r_uid_cnt + 8'd1;
                        end
                    end
                end
                s4rp_pkg::PH_HOSTNAME: begin
                    if (byte_ok && (r_host_cnt < r_max_len)) begin
                        if (i_data_byte == s4rp_pkg::CHAR_NUL) begin
                            n_phase = s4rp_pkg::PH_DONE;
                        end else begin
                            n_host_cnt = r_host_cnt + 8'd1;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // result fields
    always_comb begin
        n_status  = s4rp_pkg::ST_MORE;
        n_cvalid  = 1'b0;
        n_cval    = 8'd0;
        n_is_host = 1'b0;
        n_nlen    = 8'd0;
        if (i_op == s4rp_pkg::OP_DATA) begin
            unique case (r_phase)
                s4rp_pkg::PH_VERSION: begin
                    if (i_data_byte != s4rp_pkg::SOCKS_VERSION) n_status = s4rp_pkg::ST_REJECT;
                end
                s4rp_pkg::PH_COMMAND: begin
                    if ((i_data_byte != s4rp_pkg::CMD_CONNECT)
                            && (i_data_byte != s4rp_pkg::CMD_BIND)) begin
                        n_status = s4rp_pkg::ST_REJECT;
                    end
                end
                s4rp_pkg::PH_PORT_HI, s4rp_pkg::PH_PORT_LO, s4rp_pkg::PH_IP_1,
                s4rp_pkg::PH_IP_2, s4rp_pkg::PH_IP_3, s4rp_pkg::PH_IP_4: begin
                    n_status = s4rp_pkg::ST_MORE;
                end
                s4rp_pkg::PH_USERID: begin
                    n_nlen = n_uid_cnt;
                    if (!byte_ok || (r_uid_cnt >= r_max_len)) begin
                        n_status = s4rp_pkg::ST_REJECT;
                    end else if (i_data_byte == s4rp_pkg::CHAR_NUL) begin
                        if (!host_form) n_status = s4rp_pkg::ST_DONE;
                    end else begin
                        n_cvalid = 1'b1;
                        n_cval   = i_data_byte;
                    end
                end
                s4rp_pkg::PH_HOSTNAME: begin
                    n_is_host = 1'b1;
                    n_nlen    = n_host_cnt;
                    if (!byte_ok || (r_host_cnt >= r_max_len)) begin
                        n_status = s4rp_pkg::ST_REJECT;
                    end else if (i_data_byte == s4rp_pkg::CHAR_NUL) begin
                        n_status = s4rp_pkg::ST_DONE;
                    end else begin
                        n_cvalid = 1'b1;
                        n_cval   = i_data_byte;
                    end
                end
                default: begin
                    n_status = s4rp_pkg::ST_REJECT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= s4rp_pkg::NAME_LIMIT_RESET;
            r_phase     <= s4rp_pkg::PH_VERSION;
            r_command   <= 8'd0;
            r_port      <= 16'd0;
            r_addr      <= 32'd0;
            r_uid_cnt   <= 8'd0;
            r_host_cnt  <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_max_len <= i_cfg_data;
            if (in_fire) begin
                r_phase    <= n_phase;
                r_command  <= n_command;
                r_port     <= n_port;
                r_addr     <= n_addr;
                r_uid_cnt  <= n_uid_cnt;
                r_host_cnt <= n_host_cnt;
            end
            if (o_in_ready) r_out_valid <= i_in_valid;
        end
    end

    // result register, payload only
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status      <= n_status;
            r_out_command <= n_command;
            r_out_port    <= n_port;
            r_out_addr    <= n_addr;
            r_cvalid      <= n_cvalid;
            r_cval        <= n_cval;
            r_is_host     <= n_is_host;
            r_nlen        <= n_nlen;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_command_code     = r_out_command;
    assign o_dest_port        = r_out_port;
    assign o_dest_ip          = r_out_addr;
    assign o_name_char_valid  = r_cvalid;
    assign o_name_char        = r_cval;
    assign o_name_is_hostname = r_is_host;
    assign o_name_length      = r_nlen;

endmodule

// ===== rtl/s4rp_checker.sv =====
// port-level checks for the socks4a request parser, bound to the top level
// depends on s4rp_pkg and socks4a_request_parser

module s4rp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic        o_name_char_valid,
    input logic [7:0]  o_name_char,
    input logic [7:0]  o_name_length
);

    // no result without a transaction the cycle before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result appeared without an input transaction");

    // an appended character means the request still needs bytes
    a_char_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_name_char_valid) |->
            (o_status == s4rp_pkg::ST_MORE && o_name_char != 8'd0
             && o_name_length != 8'd0))
        else $error("name char with wrong status or length");

    // no char payload when nothing was appended
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_name_char_valid) |-> (o_name_char == 8'd0))
        else $error("name char nonzero without valid");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind socks4a_request_parser s4rp_checker u_s4rp_checker (.*);
